/* design/buffer_ring_pool_manager_unit_defines.svh */
// Assertion macros shared by the buffer ring pool manager modules.
// Include this file by its bare name where assertions are written.
`ifndef BUFFER_RING_POOL_MANAGER_UNIT_DEFINES_SVH
`define BUFFER_RING_POOL_MANAGER_UNIT_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define BRPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define BRPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/brpm_pkg.sv */
// Package of the buffer ring pool manager: widths, codes and command types.
// Used by every module of the block; depends on nothing.
package brpm_pkg;

  localparam int MaxSlots  = 16;
  localparam int IdxW      = $clog2(MaxSlots);
  localparam int CntW      = IdxW + 1;
  localparam int LineW     = 16;
  localparam int IdW       = 4;
  localparam int ByteW     = 32;
  localparam int StatusW   = 3;
  localparam int ProdW     = 2 * LineW;
  localparam int DivCntW   = $clog2(ByteW + 1);

  localparam logic [1:0] OpReqWrite = 2'd0;
  localparam logic [1:0] OpReqRead  = 2'd1;
  localparam logic [1:0] OpFinRead  = 2'd2;
  localparam logic [1:0] OpFinWrite = 2'd3;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StNone     = 3'd1;
  localparam logic [StatusW-1:0] StFinished = 3'd2;
  localparam logic [StatusW-1:0] StUnknown  = 3'd3;
  localparam logic [StatusW-1:0] StBadRange = 3'd4;

  typedef struct packed {
    logic [1:0]       operation;
    logic [LineW-1:0] line_start;
    logic [LineW-1:0] line_end;
    logic [LineW-1:0] bytes_per_line;
    logic [IdW-1:0]   buffer_id;
    logic [ByteW-1:0] written_bytes;
  } brpm_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     result_id;
    logic [LineW-1:0]   result_start_line;
    logic [LineW-1:0]   result_end_line;
    logic [LineW-1:0]   result_line_bytes;
    logic [ByteW-1:0]   result_bytes;
  } brpm_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture request, compute product
    logic decide;     // evaluate the operation with the captured product
    logic shift;      // one step of the insert shift
    logic commit_ins; // write the new slot after shifting
    logic search;     // examine one slot for the id
    logic div_start;  // start the trim divider
    logic div_step;   // one divider step
    logic trim;       // write the trimmed end line
    logic finish;     // register the result
  } brpm_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic need_insert;  // write request takes the insert path
    logic shift_done;   // shift index reached the write position
    logic search_done;  // search ended (hit or end of table)
    logic need_div;     // finish write needs the trim division
    logic div_done;     // divider has produced its quotient
    logic is_finish;
  } brpm_sts_t;

endpackage

/* design/brpm_stream_if.sv */
// Valid/ready channel interface carrying one payload of a generic type.
// Depends on nothing; the payload type comes from the instantiating scope.
interface brpm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/brpm_ctrl.sv */
// Controller state machine of the buffer ring pool manager.
// Depends on brpm_pkg and the assertion macro header.
`include "buffer_ring_pool_manager_unit_defines.svh"

module brpm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  brpm_pkg::brpm_sts_t sts_i,
  output brpm_pkg::brpm_cmd_t cmd_o
);
  import brpm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_SHIFT  = 8'b0000_1000,
    S_SEARCH = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_TRIM   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        if (sts_i.is_finish) begin
          state_d = S_SEARCH;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.need_insert) begin
          state_d = S_SHIFT;
        end else begin
          cmd_o.decide = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          cmd_o.commit_ins = 1'b1;
          cmd_o.finish     = 1'b1;
          state_d          = S_OUT;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.search_done) begin
          if (sts_i.need_div) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = S_OUT;
          end
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_TRIM;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_TRIM: begin
        cmd_o.trim   = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `BRPM_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, !out_valid_o, "ready while result pending")
  `BRPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `BRPM_ASSERT_NEXT(a_load_mul, clk_i, rst_ni, cmd_o.load, state_q == S_MUL, "load not followed by product")

endmodule

/* design/brpm_datapath.sv */
// Datapath of the buffer ring pool manager: slot table, ring pointers,
// product register, serial id search and a restoring divider.
// Depends on brpm_pkg.
module brpm_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [brpm_pkg::ByteW-1:0] max_total_bytes_i,
  input  brpm_pkg::brpm_req_t      req_i,
  input  brpm_pkg::brpm_cmd_t      cmd_i,
  output brpm_pkg::brpm_sts_t      sts_o,
  output brpm_pkg::brpm_rsp_t      rsp_o
);
  import brpm_pkg::*;

  localparam logic [ByteW:0] LineMaskV = (ByteW+1)'((1 << LineW) - 1);

  // Slot table, undefined until written.
  logic [IdW-1:0]   ident_q [MaxSlots];
  logic [ByteW-1:0] cap_q   [MaxSlots];
  logic [LineW-1:0] start_q [MaxSlots];
  logic [LineW-1:0] end_q   [MaxSlots];
  logic [LineW-1:0] lb_q    [MaxSlots];
  logic [MaxSlots-1:0] busy_q;

  logic [CntW-1:0]  count_q;
  logic [IdxW-1:0]  wpos_q, rpos_q;
  logic             filled_q;
  logic [ByteW-1:0] in_use_q;

  brpm_req_t        req_q;
  logic [ProdW-1:0] prod_q;
  logic [CntW-1:0]  sidx_q;   // shift or search index
  logic [IdxW-1:0]  hit_q;
  brpm_rsp_t        rsp_q;

  // Divider.
  logic [ByteW-1:0]   quo_q, rem_q;
  logic [DivCntW-1:0] dcnt_q;

  logic [IdxW-1:0] widx;
  assign widx = wpos_q;

  // Write decision.
  logic reuse;
  always_comb begin
    if (wpos_q != rpos_q) begin
      reuse = !busy_q[widx];
    end else if (filled_q || count_q == '0) begin
      reuse = 1'b0;
    end else begin
      reuse = !busy_q[widx];
    end
  end

  logic             bad_range;
  logic [ByteW-1:0] req32;
  logic [ByteW:0]   ins_sum;
  logic             over_budget;
  logic             table_full;
  assign bad_range   = req_q.line_end < req_q.line_start;
  assign req32       = prod_q;
  assign ins_sum     = {1'b0, in_use_q} + {1'b0, req32};
  assign over_budget = ins_sum > {1'b0, max_total_bytes_i};
  assign table_full  = count_q >= CntW'(MaxSlots);

  // Next write position after an advance, given a new count.
  function automatic logic [IdxW-1:0] adv(input logic [IdxW-1:0] p,
                                          input logic [CntW-1:0] cnt);
    logic [CntW-1:0] n;
    n = {1'b0, p} + CntW'(1);
    if (n >= cnt) begin
      n = '0;
    end
    return n[IdxW-1:0];
  endfunction

  // Reuse growth.
  logic [ByteW:0]   grow_sum;
  logic [ByteW-1:0] grow_use;
  assign grow_sum = {1'b0, in_use_q} + {1'b0, req32 - cap_q[widx]};
  assign grow_use = grow_sum[ByteW] ? '1 : grow_sum[ByteW-1:0];

  // Search.
  logic [IdxW-1:0] sslot;
  logic            s_end, s_hit;
  assign sslot  = sidx_q[IdxW-1:0];
  assign s_end  = (sidx_q >= count_q);
  assign s_hit  = !s_end && (ident_q[sslot] == req_q.buffer_id);

  // Trim inputs of the hit slot.
  logic [LineW-1:0] h_st, h_lb;
  logic [ProdW-1:0] span_prod;
  assign h_st      = start_q[hit_q];
  assign h_lb      = lb_q[hit_q];

  logic [LineW-1:0] sh_st, sh_en, sh_lb, sh_span;
  assign sh_st   = start_q[sslot];
  assign sh_en   = end_q[sslot];
  assign sh_lb   = lb_q[sslot];
  assign sh_span = (sh_en >= sh_st) ? sh_en - sh_st : '0;

  // span_prod is registered when a hit is found.
  logic [ProdW-1:0] span_prod_q;
  assign span_prod = span_prod_q;

  logic hit_busy;
  assign hit_busy = busy_q[sslot];

  logic [ByteW:0] rem_trial;
  assign rem_trial = {rem_q, quo_q[ByteW-1]} - {{(ByteW-LineW+1){1'b0}}, h_lb};

  logic [ByteW:0] ne;
  assign ne = {1'b0, quo_q} + {{(ByteW-LineW+1){1'b0}}, h_st};

  assign sts_o.need_insert = (req_q.operation == OpReqWrite) && !bad_range && !reuse
                           && !table_full && !over_budget;
  assign sts_o.shift_done  = (sidx_q == {1'b0, wpos_q});
  assign sts_o.search_done = s_end || s_hit;
  assign sts_o.need_div    = s_hit && hit_busy && (req_q.operation == OpFinWrite)
                           && (sh_lb != '0);
  assign sts_o.div_done    = (dcnt_q == '0);
  assign sts_o.is_finish   = (req_q.operation == OpFinRead) || (req_q.operation == OpFinWrite);
  assign rsp_o = rsp_q;

  // Table entries.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      ident_q[sslot] <= ident_q[sslot - IdxW'(1)];
      cap_q[sslot]   <= cap_q[sslot - IdxW'(1)];
      start_q[sslot] <= start_q[sslot - IdxW'(1)];
      end_q[sslot]   <= end_q[sslot - IdxW'(1)];
      lb_q[sslot]    <= lb_q[sslot - IdxW'(1)];
    end
    if (cmd_i.commit_ins) begin
      ident_q[widx] <= count_q[IdW-1:0];
      cap_q[widx]   <= req32;
      start_q[widx] <= req_q.line_start;
      end_q[widx]   <= req_q.line_end;
      lb_q[widx]    <= req_q.bytes_per_line;
    end
    if (cmd_i.decide && req_q.operation == OpReqWrite && !bad_range && reuse) begin
      if (cap_q[widx] < req32) begin
        cap_q[widx] <= req32;
      end
      start_q[widx] <= req_q.line_start;
      end_q[widx]   <= req_q.line_end;
      lb_q[widx]    <= req_q.bytes_per_line;
    end
    // A slot with zero bytes per line collapses to its start line unless
    // the written count matches the empty product.
    if (cmd_i.search && s_hit && hit_busy && req_q.operation == OpFinWrite
        && sh_lb == '0 && req_q.written_bytes != '0) begin
      end_q[sslot] <= sh_st;
    end
    if (cmd_i.trim && span_prod != req_q.written_bytes) begin
      end_q[hit_q] <= (ne > LineMaskV) ? LineMaskV[LineW-1:0] : ne[LineW-1:0];
    end
  end

  // Control and pointer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= '0;
      count_q  <= '0;
      wpos_q   <= '0;
      rpos_q   <= '0;
      filled_q <= 1'b0;
      in_use_q <= '0;
      sidx_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        sidx_q <= (req_i.operation == OpReqWrite) ? count_q : '0;
      end
      if (cmd_i.shift) begin
        busy_q[sslot] <= busy_q[sslot - IdxW'(1)];
        sidx_q        <= sidx_q - CntW'(1);
      end
      if (cmd_i.search && !sts_o.search_done) begin
        sidx_q <= sidx_q + CntW'(1);
      end
      if (cmd_i.search && s_hit && hit_busy) begin
        busy_q[sslot] <= 1'b0;
      end
      if (cmd_i.commit_ins) begin
        busy_q[widx] <= 1'b1;
        in_use_q     <= ins_sum[ByteW-1:0];
        if (rpos_q > wpos_q || (rpos_q == wpos_q && filled_q)) begin
          rpos_q <= rpos_q + IdxW'(1);
        end
        count_q  <= count_q + CntW'(1);
        wpos_q   <= adv(wpos_q, count_q + CntW'(1));
        filled_q <= 1'b1;
      end
      if (cmd_i.decide) begin
        if (req_q.operation == OpReqWrite && !bad_range && reuse) begin
          busy_q[widx] <= 1'b1;
          if (cap_q[widx] < req32) begin
            in_use_q <= grow_use;
          end
          wpos_q   <= adv(wpos_q, count_q);
          filled_q <= 1'b1;
        end else if (req_q.operation == OpReqRead && filled_q && count_q != '0
                     && {1'b0, rpos_q} < count_q && !busy_q[rpos_q]) begin
          busy_q[rpos_q] <= 1'b1;
          rpos_q <= adv(rpos_q, count_q);
          if (adv(rpos_q, count_q) == wpos_q) begin
            filled_q <= 1'b0;
          end
        end
      end
    end
  end

  // Request, product, search hit and divider.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_i;
    end
    prod_q <= ProdW'(req_q.line_end - req_q.line_start) * ProdW'(req_q.bytes_per_line);
    if (cmd_i.search && s_hit) begin
      hit_q       <= sslot;
      span_prod_q <= ProdW'(sh_span) * ProdW'(sh_lb);
    end
    if (cmd_i.div_start) begin
      quo_q  <= req_q.written_bytes;
      rem_q  <= '0;
      dcnt_q <= DivCntW'(ByteW);
    end else if (cmd_i.div_step) begin
      if (!rem_trial[ByteW]) begin
        rem_q <= rem_trial[ByteW-1:0];
        quo_q <= {quo_q[ByteW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[ByteW-2:0], quo_q[ByteW-1]};
        quo_q <= {quo_q[ByteW-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q - DivCntW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_q <= '0;
      unique case (req_q.operation)
        OpReqWrite: begin
          if (bad_range) begin
            rsp_q.status <= StBadRange;
          end else if (reuse) begin
            rsp_q.result_id    <= ident_q[widx];
            rsp_q.result_bytes <= req32;
          end else if (table_full || over_budget) begin
            rsp_q.status <= StNone;
          end else begin
            rsp_q.result_id    <= count_q[IdW-1:0];
            rsp_q.result_bytes <= req32;
          end
        end
        OpReqRead: begin
          if (!filled_q || count_q == '0 || {1'b0, rpos_q} >= count_q || busy_q[rpos_q]) begin
            rsp_q.status <= StNone;
          end else begin
            rsp_q.result_id         <= ident_q[rpos_q];
            rsp_q.result_start_line <= start_q[rpos_q];
            rsp_q.result_end_line   <= end_q[rpos_q];
            rsp_q.result_line_bytes <= lb_q[rpos_q];
          end
        end
        default: begin
          if (cmd_i.trim) begin
            rsp_q.status <= StOk;
          end else if (!s_hit) begin
            rsp_q.status <= StUnknown;
          end else if (!hit_busy) begin
            rsp_q.status <= StFinished;
          end
        end
      endcase
    end
  end

endmodule

/* design/buffer_ring_pool_manager_unit.sv */
// Top level of the buffer ring pool manager.
// Depends on brpm_pkg, brpm_stream_if, brpm_ctrl and brpm_datapath.
//
//  Channel   Direction  Payload
//  req       sink       brpm_req_t: operation, lines, bytes per line, id, written bytes
//  rsp       source     brpm_rsp_t: status, id, line range, line bytes, granted bytes
//  cfg       input      max_total_bytes, written when cfg_we_i is high
//
// One transaction is taken at a time; a request holds the block until the
// next is accepted. A read or a plain write passes the product and decide
// states, a write that inserts walks the later slots one per cycle, a finish
// searches the slot table one slot per cycle, and a finish write that trims
// adds a 32-step serial divider. The result holds until it is taken; reset
// clears the pointers, counts and busy marks, and the table needs no clearing.
module buffer_ring_pool_manager_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [brpm_pkg::ByteW-1:0]   cfg_wdata_i,
  brpm_stream_if.sink                  req,
  brpm_stream_if.source                rsp
);
  import brpm_pkg::*;

  logic [ByteW-1:0] max_total_bytes_q;
  brpm_cmd_t cmd;
  brpm_sts_t sts;
  brpm_rsp_t rsp_data;

  // The budget register resets to 16 MiB.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_total_bytes_q <= ByteW'(32'h0100_0000);
    end else if (cfg_we_i) begin
      max_total_bytes_q <= cfg_wdata_i;
    end
  end

  brpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brpm_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .max_total_bytes_i (max_total_bytes_q),
    .req_i             (req.data),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .rsp_o             (rsp_data)
  );

  assign rsp.data = rsp_data;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench of the buffer ring pool manager unit.
// Depends on brpm_pkg, brpm_stream_if and buffer_ring_pool_manager_unit.
module tb_top;
  import brpm_pkg::*;

  localparam int ReqBits = $bits(brpm_req_t);

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ByteW-1:0] cfg_wdata_i;

  brpm_stream_if #(.T(brpm_req_t)) req_ch ();
  brpm_stream_if #(.T(brpm_rsp_t)) rsp_ch ();

  buffer_ring_pool_manager_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch.sink),
    .rsp        (rsp_ch.source)
  );

  // The longest request is a search plus the trim divider, so the quiet
  // period covers any work still in flight.
  localparam int DrainCycles = 64;

  // Shadow copy of the slot table, pointers and budget.
  logic [IdW-1:0]   pool_ident [MaxSlots];
  logic [ByteW-1:0] pool_cap   [MaxSlots];
  logic [LineW-1:0] pool_start [MaxSlots];
  logic [LineW-1:0] pool_end   [MaxSlots];
  logic [LineW-1:0] pool_lbytes[MaxSlots];
  logic             pool_busy  [MaxSlots];
  int               pool_count;
  int               pool_wpos;
  int               pool_rpos;
  logic             pool_filled;
  logic [ByteW-1:0] pool_used;
  logic [ByteW-1:0] pool_budget;

  brpm_rsp_t pending_rsp[$];
  int        mismatches;
  bit        idle_on;      // random gaps on both channels
  int        hold_left;    // long stall of the result channel, in cycles

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // Advance the pool model by one accepted transaction; return its result.
  function automatic brpm_rsp_t pool_apply(brpm_req_t r);
    brpm_rsp_t o;
    logic [63:0] need, need32, grown, span, new_end;
    bit reuse;
    int s, i;
    o = '0;
    case (r.operation)
      OpReqWrite: begin
        if (r.line_end < r.line_start) begin
          o.status = StBadRange;
        end else begin
          need = 64'(r.line_end - r.line_start) * 64'(r.bytes_per_line);
          need32 = (need > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : need;
          if (pool_wpos != pool_rpos) reuse = !pool_busy[pool_wpos];
          else if (pool_filled || pool_count == 0) reuse = 1'b0;
          else reuse = !pool_busy[pool_wpos];
          if (reuse) begin
            s = pool_wpos;
            pool_wpos = (pool_wpos + 1 >= pool_count) ? 0 : pool_wpos + 1;
            pool_filled = 1'b1;
            if (64'(pool_cap[s]) < need32) begin
              // Growth is not held to the budget; the usage count saturates.
              grown = 64'(pool_used) + (need32 - 64'(pool_cap[s]));
              pool_used = (grown > 64'hFFFF_FFFF) ? '1 : grown[31:0];
              pool_cap[s] = need32[31:0];
            end
            pool_busy[s] = 1'b1;
            pool_start[s] = r.line_start;
            pool_end[s] = r.line_end;
            pool_lbytes[s] = r.bytes_per_line;
            o.result_id = pool_ident[s];
            o.result_bytes = need32[31:0];
          end else if (pool_count >= MaxSlots ||
                       64'(pool_used) + need > 64'(pool_budget)) begin
            o.status = StNone;
          end else begin
            s = pool_wpos;
            for (i = pool_count; i > s; i--) begin
              pool_ident[i] = pool_ident[i-1];
              pool_cap[i] = pool_cap[i-1];
              pool_start[i] = pool_start[i-1];
              pool_end[i] = pool_end[i-1];
              pool_lbytes[i] = pool_lbytes[i-1];
              pool_busy[i] = pool_busy[i-1];
            end
            pool_ident[s] = IdW'(pool_count);
            pool_cap[s] = need32[31:0];
            pool_used = pool_used + need[31:0];
            if (pool_rpos > pool_wpos || (pool_rpos == pool_wpos && pool_filled))
              pool_rpos++;
            pool_count++;
            pool_wpos = (pool_wpos + 1 >= pool_count) ? 0 : pool_wpos + 1;
            pool_filled = 1'b1;
            pool_busy[s] = 1'b1;
            pool_start[s] = r.line_start;
            pool_end[s] = r.line_end;
            pool_lbytes[s] = r.bytes_per_line;
            o.result_id = pool_ident[s];
            o.result_bytes = need32[31:0];
          end
        end
      end
      OpReqRead: begin
        if (!pool_filled || pool_count == 0 || pool_rpos >= pool_count ||
            pool_busy[pool_rpos]) begin
          o.status = StNone;
        end else begin
          s = pool_rpos;
          pool_rpos = (pool_rpos + 1 >= pool_count) ? 0 : pool_rpos + 1;
          if (pool_rpos == pool_wpos) pool_filled = 1'b0;
          pool_busy[s] = 1'b1;
          o.result_id = pool_ident[s];
          o.result_start_line = pool_start[s];
          o.result_end_line = pool_end[s];
          o.result_line_bytes = pool_lbytes[s];
        end
      end
      default: begin
        // Lowest-numbered slot with a matching id wins.
        s = -1;
        for (i = 0; i < pool_count; i++)
          if (s < 0 && pool_ident[i] == r.buffer_id) s = i;
        if (s < 0) begin
          o.status = StUnknown;
        end else if (!pool_busy[s]) begin
          o.status = StFinished;
        end else begin
          pool_busy[s] = 1'b0;
          if (r.operation == OpFinWrite) begin
            span = (pool_end[s] >= pool_start[s]) ? 64'(pool_end[s] - pool_start[s]) : 0;
            if (span * 64'(pool_lbytes[s]) != 64'(r.written_bytes)) begin
              if (pool_lbytes[s] == 0) begin
                pool_end[s] = pool_start[s];
              end else begin
                new_end = 64'(pool_start[s]) + 64'(r.written_bytes) / 64'(pool_lbytes[s]);
                pool_end[s] = (new_end > 64'hFFFF) ? '1 : new_end[15:0];
              end
            end
          end
        end
      end
    endcase
    return o;
  endfunction

  // Result channel: random stalls, plus a long hold when asked for.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest pending prediction.
  always @(posedge clk_i) begin
    brpm_rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result transaction with no prediction pending");
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.data.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, rsp_ch.data.status);
          mismatches++;
        end
        if (rsp_ch.data.result_id !== want.result_id) begin
          $error("result_id expected %0d actual %0d", want.result_id,
                 rsp_ch.data.result_id);
          mismatches++;
        end
        if (rsp_ch.data.result_start_line !== want.result_start_line) begin
          $error("result_start_line expected %0d actual %0d", want.result_start_line,
                 rsp_ch.data.result_start_line);
          mismatches++;
        end
        if (rsp_ch.data.result_end_line !== want.result_end_line) begin
          $error("result_end_line expected %0d actual %0d", want.result_end_line,
                 rsp_ch.data.result_end_line);
          mismatches++;
        end
        if (rsp_ch.data.result_line_bytes !== want.result_line_bytes) begin
          $error("result_line_bytes expected %0d actual %0d", want.result_line_bytes,
                 rsp_ch.data.result_line_bytes);
          mismatches++;
        end
        if (rsp_ch.data.result_bytes !== want.result_bytes) begin
          $error("result_bytes expected %0h actual %0h", want.result_bytes,
                 rsp_ch.data.result_bytes);
          mismatches++;
        end
      end
    end
  end

  // Offer one request and block until it is accepted. Valid stays high after
  // acceptance between back-to-back transactions; a gap lowers it first.
  task automatic send_request(brpm_req_t r);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    pending_rsp.push_back(pool_apply(r));
  endtask

  function automatic brpm_req_t make_req(logic [1:0] op, int f, int l, int b,
                                         int id, logic [31:0] wr);
    brpm_req_t r;
    r.operation = op;
    r.line_start = LineW'(f);
    r.line_end = LineW'(l);
    r.bytes_per_line = LineW'(b);
    r.buffer_id = IdW'(id);
    r.written_bytes = wr;
    return r;
  endfunction

  // Wait until every result has come back and the block is quiet.
  task automatic drain;
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_budget(logic [31:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pool_budget = v;
  endtask

  // Id of a busy slot when one exists, so finishes mostly hit real buffers.
  function automatic int busy_id();
    int cand[$];
    for (int i = 0; i < pool_count; i++)
      if (pool_busy[i]) cand.push_back(pool_ident[i]);
    if (cand.size() == 0) return $urandom_range(0, 15);
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // One random transaction; well-formed pool traffic dominates.
  task automatic send_random;
    int pick, f, len, b, sel;
    logic [31:0] wr;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_request(brpm_req_t'(ReqBits'({$urandom, $urandom, $urandom})));
    end else if (pick < 40) begin
      f = $urandom_range(0, 4000);
      len = $urandom_range(0, 64);
      b = $urandom_range(0, 4096);
      if ($urandom_range(0, 19) == 0) len = -$urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) f = $urandom_range(0, 65535);
      send_request(make_req(OpReqWrite, f, f + len, b, $urandom, $urandom));
    end else if (pick < 65) begin
      send_request(make_req(OpReqRead, $urandom, $urandom, $urandom, $urandom, $urandom));
    end else begin
      sel = busy_id();
      if ($urandom_range(0, 9) == 0) sel = $urandom_range(0, 15);
      wr = $urandom_range(0, 300000);
      for (int i = 0; i < pool_count; i++)
        if (pool_ident[i] == IdW'(sel) && $urandom_range(0, 2) == 0)
          wr = 32'(pool_end[i] - pool_start[i]) * 32'(pool_lbytes[i]);
      if ($urandom_range(0, 9) == 0) wr = $urandom;
      if ($urandom_range(0, 9) == 0) wr = 0;
      send_request(make_req((pick < 82) ? OpFinRead : OpFinWrite, $urandom, $urandom,
                            $urandom, sel, wr));
    end
  endtask

  // Every operation, the field extremes and each special case.
  task automatic test_directed;
    send_request(make_req(OpReqRead, 0, 0, 0, 0, 0));          // read on empty pool
    send_request(make_req(OpFinRead, 0, 0, 0, 5, 0));          // id held by no slot
    send_request(make_req(OpReqWrite, 10, 9, 100, 0, 0));      // reversed range
    send_request(make_req(OpReqWrite, 0, 65535, 65535, 15, '1));
    send_request(make_req(OpReqWrite, 100, 100, 0, 0, 0));     // empty range
    send_request(make_req(OpReqWrite, 65535, 65535, 65535, 0, 0));
    send_request(make_req(OpReqRead, 0, 0, 0, 0, 0));
    send_request(make_req(OpReqRead, 0, 0, 0, 0, 0));
    send_request(make_req(OpFinRead, 0, 0, 0, 0, 0));
    send_request(make_req(OpFinRead, 0, 0, 0, 0, 0));          // already finished
    send_request(make_req(OpFinWrite, 0, 0, 0, 1, 0));         // zero bytes written, empty span
    send_request(make_req(OpFinWrite, 0, 0, 0, 2, '1));        // id held by no slot
    send_request(make_req(OpFinWrite, 0, 0, 0, 0, 100));       // finish write on a finished slot
    send_request(make_req(OpReqWrite, 1, 3, 7, 0, 0));         // insert, no free slot to reuse
    // Fill the table until inserts are refused.
    for (int i = 0; i < 15; i++)
      send_request(make_req(OpReqWrite, i, i + 2, 16, 0, 0));
    send_request(make_req(OpFinWrite, 0, 0, 0, 15, 0));
  endtask

  // The budget register at both extremes.
  task automatic test_budget;
    program_budget(32'd0);
    for (int i = 0; i < 6; i++) send_random();
    program_budget(32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_random();
  endtask

  task automatic test_random(int n, logic [31:0] budget);
    program_budget(budget);
    for (int i = 0; i < n; i++) send_random();
  endtask

  // The result channel holds off while requests keep coming, so the block
  // holds its result and stalls its input.
  task automatic test_backpressure;
    drain();
    hold_left = 400;
    for (int i = 0; i < 20; i++) send_random();
  endtask

  initial begin
    mismatches = 0;
    hold_left = 0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    for (int i = 0; i < MaxSlots; i++) begin
      pool_ident[i] = '0;
      pool_cap[i] = '0;
      pool_start[i] = '0;
      pool_end[i] = '0;
      pool_lbytes[i] = '0;
      pool_busy[i] = 1'b0;
    end
    pool_count = 0;
    pool_wpos = 0;
    pool_rpos = 0;
    pool_filled = 1'b0;
    pool_used = '0;
    pool_budget = 32'd16777216;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_budget();
    test_random(350, 32'd16777216);
    test_backpressure();
    test_random(350, 32'd200000);
    test_random(350, 32'd3000000);
    drain();
    idle_on = 1'b0;
    test_random(300, 32'hFFFF_FFFF);
    drain();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
